// File: rtl/hidbkr_pkg.sv
// hidbkr_pkg: shared types, constants and usage rom for the boot keyboard report block
// no dependencies; used by hidbkr_key_cell and hid_boot_keyboard_report_core
package hidbkr_pkg;

	localparam int KEY_CAPACITY     = 16;
	localparam int KEY_IDX_W        = $clog2(KEY_CAPACITY);
	localparam int COUNT_W          = $clog2(KEY_CAPACITY + 1);
	localparam int REPORT_KEY_SLOTS = 6;

	localparam logic [3:0] VALID_ENDPOINT = 4'd1;
	localparam logic [6:0] REPORT_LENGTH  = 7'd8;
	localparam logic [7:0] ROLLOVER_CODE  = 8'h01;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_NACK  = 2'd1,
		STATUS_STALL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic [3:0] endpoint;
		logic [6:0] transfer_length;
		logic       event_valid;
		logic [7:0] key_code;
		logic       key_released;
		logic [7:0] modifier_bits;
	} poll_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] report_modifiers;
		logic [7:0] key_slot_0;
		logic [7:0] key_slot_1;
		logic [7:0] key_slot_2;
		logic [7:0] key_slot_3;
		logic [7:0] key_slot_4;
		logic [7:0] key_slot_5;
	} report_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	localparam logic [7:0] USAGE_ROM [0:255] = '{
		8'h00, 8'h29, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23,
		8'h24, 8'h25, 8'h26, 8'h27, 8'h2d, 8'h2e, 8'h2a, 8'h2b,
		8'h14, 8'h1a, 8'h08, 8'h15, 8'h17, 8'h1c, 8'h18, 8'h0c,
		8'h12, 8'h13, 8'h2f, 8'h30, 8'h28, 8'he0, 8'h04, 8'h16,
		8'h07, 8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h0f, 8'h33,
		8'h34, 8'h35, 8'he1, 8'h31, 8'h1d, 8'h1b, 8'h06, 8'h19,
		8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'he5, 8'h55,
		8'he2, 8'h2c, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e,
		8'h3f, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5f,
		8'h60, 8'h61, 8'h56, 8'h5c, 8'h5d, 8'h5e, 8'h57, 8'h59,
		8'h5a, 8'h5b, 8'h62, 8'h63, 8'hff, 8'h94, 8'h64, 8'h44,
		8'h45, 8'h87, 8'h92, 8'h93, 8'h8a, 8'h88, 8'h8b, 8'h8c,
		8'h58, 8'he4, 8'h54, 8'h46, 8'he6, 8'h00, 8'h4a, 8'h52,
		8'h4b, 8'h50, 8'h4f, 8'h4d, 8'h51, 8'h4e, 8'h49, 8'h4c,
		8'h00, 8'h7f, 8'h81, 8'h80, 8'h66, 8'h67, 8'h00, 8'h48,
		8'h00, 8'h85, 8'h90, 8'h91, 8'h89, 8'he3, 8'he7, 8'h65,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff
	};

endpackage

// File: rtl/hidbkr_key_cell.sv
// hidbkr_key_cell: one entry of the pressed-key ring, takes its neighbour or a new usage
// depends on hidbkr_pkg (cell_ctrl_t)
module hidbkr_key_cell (
	input  logic                   clk,
	input  hidbkr_pkg::cell_ctrl_t ctrl,
	input  logic [7:0]             nbr_key,
	input  logic [7:0]             load_key,
	output logic [7:0]             key
);

	logic [7:0] key_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			key_q <= load_key;
		end else if (ctrl.shift) begin
			key_q <= nbr_key;
		end
	end

	assign key = key_q;

endmodule

// File: rtl/hid_boot_keyboard_report_core.sv
// hid_boot_keyboard_report_core: boot keyboard interrupt in report generator, top level
// depends on hidbkr_pkg and hidbkr_key_cell
// a rejected poll or one with no key event goes straight to the report state; with a key event the
// block first searches the key ring in one full rotation, then updates it, then loads the report
// throughput: the next poll is taken the cycle after the report register is loaded
// reset: key count cleared, ring contents undefined until written, no clearing pass
module hid_boot_keyboard_report_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                poll_valid,
	output logic                poll_ready,
	input  hidbkr_pkg::poll_t   poll,
	output logic                report_valid,
	input  logic                report_ready,
	output hidbkr_pkg::report_t report
);

	localparam int N = hidbkr_pkg::KEY_CAPACITY;
	localparam int IW = hidbkr_pkg::KEY_IDX_W;
	localparam int CW = hidbkr_pkg::COUNT_W;

	hidbkr_pkg::state_t     state_q, state_d;
	hidbkr_pkg::poll_t      item_q;
	hidbkr_pkg::status_t    status_q;
	hidbkr_pkg::report_t    report_q, report_d;
	hidbkr_pkg::cell_ctrl_t ctrl [N];
	logic [7:0]             keys [N];
	logic [7:0]             usage_q;
	logic [CW-1:0]          count_q;
	logic [IW-1:0]          step_q;
	logic [IW-1:0]          pos_q;
	logic                   found_q;
	logic                   report_valid_q;
	logic                   accept;
	logic                   head_hit;
	logic                   remove_en;
	logic                   add_en;
	logic                   report_load;
	logic                   good_event;

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			if (gi < N - 1) begin : g_mid
				hidbkr_key_cell u_cell (
					.clk      (clk),
					.ctrl     (ctrl[gi]),
					.nbr_key  (keys[gi + 1]),
					.load_key (usage_q),
					.key      (keys[gi])
				);
			end else begin : g_tail
				hidbkr_key_cell u_cell (
					.clk      (clk),
					.ctrl     (ctrl[gi]),
					.nbr_key  (keys[0]),
					.load_key (usage_q),
					.key      (keys[gi])
				);
			end
		end
	endgenerate

	assign accept     = poll_valid && poll_ready;
	assign good_event = (poll.endpoint == hidbkr_pkg::VALID_ENDPOINT)
		&& (poll.transfer_length == hidbkr_pkg::REPORT_LENGTH) && poll.event_valid;
	assign head_hit   = !found_q && (keys[0] == usage_q) && (CW'(step_q) < count_q);
	assign remove_en  = item_q.key_released && found_q;
	assign add_en     = !item_q.key_released && !found_q && (count_q < CW'(N));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hidbkr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		poll_ready  = 1'b0;
		report_load = 1'b0;
		for (int i = 0; i < N; i++) begin
			ctrl[i] = '0;
		end
		case (state_q)
			hidbkr_pkg::ST_IDLE: begin
				poll_ready = 1'b1;
				if (poll_valid) begin
					state_d = good_event ? hidbkr_pkg::ST_SEARCH : hidbkr_pkg::ST_REPORT;
				end
			end
			hidbkr_pkg::ST_SEARCH: begin
				for (int i = 0; i < N; i++) begin
					ctrl[i].shift = 1'b1;
				end
				if (step_q == IW'(N - 1)) begin
					state_d = hidbkr_pkg::ST_UPDATE;
				end
			end
			hidbkr_pkg::ST_UPDATE: begin
				for (int i = 0; i < N; i++) begin
					ctrl[i].shift = remove_en && (pos_q <= IW'(i));
					ctrl[i].load  = add_en && (count_q == CW'(i));
				end
				state_d = hidbkr_pkg::ST_REPORT;
			end
			hidbkr_pkg::ST_REPORT: begin
				if (!report_valid_q || report_ready) begin
					report_load = 1'b1;
					state_d     = hidbkr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hidbkr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q  <= poll;
			usage_q <= hidbkr_pkg::USAGE_ROM[poll.key_code];
			if (poll.endpoint != hidbkr_pkg::VALID_ENDPOINT) begin
				status_q <= hidbkr_pkg::STATUS_NACK;
			end else if (poll.transfer_length != hidbkr_pkg::REPORT_LENGTH) begin
				status_q <= hidbkr_pkg::STATUS_STALL;
			end else begin
				status_q <= hidbkr_pkg::STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			step_q  <= '0;
			pos_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (accept) begin
				step_q  <= '0;
				found_q <= 1'b0;
			end
			if (state_q == hidbkr_pkg::ST_SEARCH) begin
				step_q <= step_q + 1'b1;
				if (head_hit) begin
					found_q <= 1'b1;
					pos_q   <= step_q;
				end
			end
			if (state_q == hidbkr_pkg::ST_UPDATE) begin
				if (remove_en) begin
					count_q <= count_q - 1'b1;
				end else if (add_en) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// report assembly from the front of the ring
	always_comb begin
		logic [7:0] slot [hidbkr_pkg::REPORT_KEY_SLOTS];
		for (int j = 0; j < hidbkr_pkg::REPORT_KEY_SLOTS; j++) begin
			slot[j] = (CW'(j) < count_q) ? keys[j] : 8'h00;
		end
		if (count_q > CW'(hidbkr_pkg::REPORT_KEY_SLOTS)) begin
			slot[hidbkr_pkg::REPORT_KEY_SLOTS - 1] = hidbkr_pkg::ROLLOVER_CODE;
		end
		report_d        = '0;
		report_d.status = status_q;
		if (status_q == hidbkr_pkg::STATUS_OK) begin
			report_d.report_modifiers = item_q.modifier_bits;
			report_d.key_slot_0       = slot[0];
			report_d.key_slot_1       = slot[1];
			report_d.key_slot_2       = slot[2];
			report_d.key_slot_3       = slot[3];
			report_d.key_slot_4       = slot[4];
			report_d.key_slot_5       = slot[5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_valid_q <= 1'b0;
		end else if (report_load) begin
			report_valid_q <= 1'b1;
		end else if (report_ready) begin
			report_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report_load) begin
			report_q <= report_d;
		end
	end

	assign report_valid = report_valid_q;
	assign report       = report_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N))
		else $error("key count above capacity");

	a_count_only_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != hidbkr_pkg::ST_UPDATE |=> count_q == $past(count_q))
		else $error("key count changed outside update");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hidbkr_pkg::ST_UPDATE |=> (count_q == $past(count_q))
			|| (count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1))
		else $error("key count moved by more than one");

	a_bad_poll_no_search: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (poll.endpoint != hidbkr_pkg::VALID_ENDPOINT)
			|=> state_q == hidbkr_pkg::ST_REPORT)
		else $error("rejected poll entered the key search");

	a_search_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == hidbkr_pkg::ST_SEARCH) |-> step_q == '0)
		else $error("ring search ended before a full rotation");
`endif

endmodule
